>>> sv/tobc_pkg.sv
// Package: shared types and constants for the tagged-operand byte core.
`default_nettype none
package tobc_pkg;
   localparam int MEM_DEPTH = 128;
   localparam int MEM_AW = $clog2(MEM_DEPTH);
   localparam int NREGS = 16;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_EXEC  = 2'd1;
   localparam logic [1:0] CMD_SETPC = 2'd2;

   localparam logic [7:0] OP_MOV = 8'd1;
   localparam logic [7:0] OP_ADD = 8'd2;
   localparam logic [7:0] OP_SUB = 8'd3;
   localparam logic [7:0] OP_JIF = 8'd4;
   localparam logic [7:0] OP_JMR = 8'd5;
   localparam logic [7:0] OP_MPC = 8'd6;
   localparam logic [7:0] OP_IN  = 8'd7;
   localparam logic [7:0] OP_OUT = 8'd8;
   localparam logic [7:0] OP_AT  = 8'd9;
   localparam logic [7:0] OP_ATP = 8'd10;

   localparam logic [1:0] KIND_NONE = 2'd0;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      DP_NOP,
      DP_MEMWR,   // write mem_byte at mem_address
      DP_SETPC,   // pc <= start_pc
      DP_FETCH,   // issue memory read at pc, pc++
      DP_LATOP,   // opcode <= rdata
      DP_LATA,    // operand a <= rdata
      DP_LATB,    // operand b <= rdata
      DP_RDLOC,   // issue read of location addr_sel
      DP_LATX,    // x <= value of loc/imm for selected operand
      DP_LATY,    // y <= value
      DP_EXEC,    // perform op and writeback
      DP_RESULT   // clear response fields, no state change
   } dp_op_type;

   typedef enum logic [1:0] {
      SEL_A,
      SEL_B,
      SEL_X
   } sel_type;

   typedef struct packed {
      dp_op_type op;
      sel_type   sel;
   } dp_cmd_type;

   typedef struct packed {
      logic [7:0] opcode;
   } dp_status_type;
endpackage
`default_nettype wire

>>> sv/tagged_operand_byte_cpu_core.sv
// Top level of the tagged-operand byte core.
// Usage:
//   One request transaction carries a command: write a memory byte, execute
//   one instruction, or set the program counter. Each request produces
//   exactly one response transaction with OUT data, IN consumption, halt,
//   the program counter and the flags after the command.
//   Memory write, set-pc and the unused command respond in the cycle after
//   the request is taken. An executed instruction fetches its opcode and,
//   unless it is undefined, operands a, b, x and y (JMR, MPC skip b and x);
//   the single memory port serializes fetches and operand reads.
//   A new request is taken in the cycle its predecessor's response is
//   taken. If the receiver stalls, the response holds and no new request
//   is taken. Reset clears pc, flags and the 16 registers; memory is not
//   cleared and must be loaded before it is read.
`default_nettype none
module tagged_operand_byte_cpu_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [6:0]  req_mem_address,
   input  wire logic [7:0]  req_mem_byte,
   input  wire logic [6:0]  req_start_pc,
   input  wire logic [31:0] req_in_value,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_out_kind,
   output      logic [31:0] rsp_out_value,
   output      logic        rsp_in_taken,
   output      logic        rsp_halted,
   output      logic [6:0]  rsp_pc_after,
   output      logic        rsp_zero_flag,
   output      logic        rsp_carry_flag
);
   import tobc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [31:0]   iv_ff;
   logic          acc;

   assign acc = req_valid && req_ready;
   always_ff @(posedge clock) begin
      if (acc) begin
         iv_ff <= req_in_value;
      end
   end

   tobc_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd)
   );

   tobc_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .mem_address(req_mem_address),
      .mem_byte(req_mem_byte), .start_pc(req_start_pc), .in_value(iv_ff),
      .status(status),
      .out_kind(rsp_out_kind), .out_value(rsp_out_value),
      .in_taken(rsp_in_taken), .halted(rsp_halted), .pc_after(rsp_pc_after),
      .zero_flag(rsp_zero_flag), .carry_flag(rsp_carry_flag)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request accepted while response stalled");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pc_after)))
      else $error("response changed while stalled");
   a_resp_after_req: assert property (@(posedge clock) disable iff (reset)
      (acc && req_command != CMD_EXEC) |=> rsp_valid)
      else $error("simple command missed response");
endmodule
`default_nettype wire

>>> sv/tobc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module tobc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule
`default_nettype wire

>>> sv/tobc_datapath.sv
// Datapath: pc, registers, flags, operand latches, memory port and result.
`default_nettype none
module tobc_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tobc_pkg::dp_cmd_type cmd,
   input  wire logic [6:0]           mem_address,
   input  wire logic [7:0]           mem_byte,
   input  wire logic [6:0]           start_pc,
   input  wire logic [31:0]          in_value,
   output      tobc_pkg::dp_status_type status,
   output      logic [1:0]           out_kind,
   output      logic [31:0]          out_value,
   output      logic                 in_taken,
   output      logic                 halted,
   output      logic [6:0]           pc_after,
   output      logic                 zero_flag,
   output      logic                 carry_flag
);
   import tobc_pkg::*;

   logic [6:0]  pc_ff, pc_in;
   logic [1:0]  flags_ff, flags_in;
   logic [30:0] regs_ff [NREGS];
   logic [7:0]  op_ff, a_ff, b_ff;
   logic [31:0] x_ff, y_ff;
   logic [6:0]  loc_ff;          // location last issued for read
   logic [1:0]  kind_ff;
   logic [31:0] oval_ff;
   logic        taken_ff, halt_ff;

   logic              we;
   logic [MEM_AW-1:0] addr;
   logic [7:0]        wdata, rdata;

   tobc_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   logic [7:0]  selb;
   logic [6:0]  sel_loc;
   logic [31:0] loc_val, opnd_val;
   logic [31:0] sum, diff, res;
   logic        rcarry;
   logic [6:0]  wloc;
   logic [31:0] wval;
   logic        wen;
   logic        known;

   assign status.opcode = op_ff;

   always_comb begin
      case (cmd.sel)
         SEL_A:   selb = a_ff;
         SEL_B:   selb = b_ff;
         default: selb = {x_ff[6:0], 1'b0};
      endcase
      sel_loc = selb[7:1];
      // value of loc_ff, given memory read issued the cycle before
      if (loc_ff < 7'(NREGS)) begin
         loc_val = {1'b0, regs_ff[loc_ff[3:0]]};
      end else begin
         loc_val = {24'd0, rdata};
      end
      opnd_val = selb[0] ? {25'd0, selb[7:1]} : loc_val;
      sum  = x_ff + y_ff;
      diff = x_ff - y_ff;
   end

   // execute: compute write target and value, next pc and flags
   always_comb begin
      wen = 1'b0;
      wloc = b_ff[7:1];
      wval = y_ff;
      res = 32'd0;
      rcarry = 1'b0;
      pc_in = pc_ff;
      flags_in = flags_ff;
      known = 1'b1;
      case (op_ff)
         OP_MOV: begin
            wen = ~b_ff[0];
         end
         OP_ADD, OP_SUB: begin
            res = (op_ff == OP_ADD) ? sum : diff;
            rcarry = (op_ff == OP_ADD) ? (sum < x_ff) : (diff > x_ff);
            flags_in = {rcarry, res == 32'd0};
            wen = ~b_ff[0];
            wval = res;
         end
         OP_JIF: begin
            if ((flags_ff & a_ff[1:0]) == 2'd0) begin
               pc_in = x_ff[6:0];
            end
         end
         OP_JMR: pc_in = y_ff[6:0];
         OP_MPC: begin
            wen = ~a_ff[0];
            wloc = a_ff[7:1];
            wval = {25'd0, pc_ff};
         end
         OP_IN: begin
            wen = ~b_ff[0];
            wval = (a_ff <= 8'd1) ? in_value : 32'd0;
         end
         OP_OUT: ;
         OP_AT: begin
            wen = ~b_ff[0];
         end
         OP_ATP: begin
            wen = 1'b1;
            wloc = x_ff[6:0];
         end
         default: known = 1'b0;
      endcase
   end

   always_comb begin
      we = 1'b0;
      addr = MEM_AW'(pc_ff);
      wdata = wval[7:0];
      case (cmd.op)
         DP_MEMWR: begin
            we = 1'b1;
            addr = MEM_AW'(mem_address);
            wdata = mem_byte;
         end
         DP_FETCH: addr = MEM_AW'(pc_ff);
         DP_RDLOC: addr = MEM_AW'(sel_loc);
         DP_EXEC: begin
            we = wen && (wloc >= 7'(NREGS));
            addr = MEM_AW'(wloc);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= 7'd0;
         flags_ff <= 2'd0;
         for (int i = 0; i < NREGS; i++) regs_ff[i] <= 31'd0;
      end else begin
         case (cmd.op)
            DP_SETPC: pc_ff <= start_pc;
            DP_FETCH: pc_ff <= pc_ff + 7'd1;
            DP_EXEC: begin
               pc_ff <= pc_in;
               flags_ff <= flags_in;
               if (wen && wloc < 7'(NREGS)) regs_ff[wloc[3:0]] <= wval[30:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LATOP: op_ff <= rdata;
         DP_LATA:  a_ff <= rdata;
         DP_LATB:  b_ff <= rdata;
         DP_RDLOC: loc_ff <= sel_loc;
         DP_LATX:  x_ff <= opnd_val;
         DP_LATY:  y_ff <= opnd_val;
         default: ;
      endcase
      if (cmd.op == DP_FETCH || cmd.op == DP_MEMWR || cmd.op == DP_SETPC ||
          cmd.op == DP_RESULT) begin
         kind_ff <= KIND_NONE;
         oval_ff <= 32'd0;
         taken_ff <= 1'b0;
         halt_ff <= 1'b0;
      end
      if (cmd.op == DP_EXEC) begin
         taken_ff <= (op_ff == OP_IN) && (a_ff <= 8'd1);
         halt_ff <= ~known || (op_ff == 8'd0);
         if (op_ff == OP_OUT && a_ff <= 8'd1) begin
            kind_ff <= a_ff[1:0] + 2'd1;
            oval_ff <= x_ff;
         end
      end
   end

   assign out_kind = kind_ff;
   assign out_value = oval_ff;
   assign in_taken = taken_ff;
   assign halted = halt_ff;
   assign pc_after = pc_ff;
   assign zero_flag = flags_ff[0];
   assign carry_flag = flags_ff[1];
endmodule
`default_nettype wire

>>> sv/tobc_control.sv
// Controller: sequences fetch, operand read, execute and the handshake.
`default_nettype none
module tobc_control (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic [1:0]              req_command,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire tobc_pkg::dp_status_type status,
   output      tobc_pkg::dp_cmd_type    cmd
);
   import tobc_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_OP    = 13'b0000000000010,
      S_AW    = 13'b0000000000100,
      S_A     = 13'b0000000001000,
      S_BW    = 13'b0000000010000,
      S_B     = 13'b0000000100000,
      S_R1    = 13'b0000001000000,
      S_X     = 13'b0000010000000,
      S_R2    = 13'b0000100000000,
      S_Y     = 13'b0001000000000,
      S_R3    = 13'b0010000000000,
      S_EXEC  = 13'b0100000000000,
      S_RSP   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] op;
   assign op = status.opcode;

   assign req_ready = (state_ff == S_IDLE) || (state_ff == S_RSP && rsp_ready);
   assign rsp_valid = (state_ff == S_RSP);

   // plan per opcode:
   // x: MOV/ADD/SUB: b; JIF: b; OUT: b; AT: a(then X indirect into y); ATP: b
   // y: MOV/ADD/SUB: a; JMR: a; AT: loc(x); ATP: a
   always_comb begin
      state_in = state_ff;
      cmd = '{op: DP_NOP, sel: SEL_A};
      case (state_ff)
         S_IDLE, S_RSP: begin
            if (req_valid && req_ready) begin
               case (req_command)
                  CMD_WRITE: begin cmd.op = DP_MEMWR; state_in = S_RSP; end
                  CMD_SETPC: begin cmd.op = DP_SETPC; state_in = S_RSP; end
                  CMD_EXEC:  begin cmd.op = DP_FETCH; state_in = S_OP; end
                  default: begin
                     cmd.op = DP_RESULT;
                     state_in = S_RSP;
                  end
               endcase
            end else if (state_ff == S_RSP && rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         S_OP: begin
            cmd.op = DP_LATOP;
            state_in = S_AW;
         end
         S_AW: begin
            if (op >= OP_MOV && op <= OP_ATP) begin
               cmd.op = DP_FETCH;
               state_in = S_A;
            end else begin
               cmd.op = DP_EXEC;
               state_in = S_RSP;
            end
         end
         S_A: begin
            cmd.op = DP_LATA;
            state_in = (op == OP_JMR || op == OP_MPC) ? S_R2 : S_BW;
         end
         S_BW: begin cmd.op = DP_FETCH; state_in = S_B; end
         S_B: begin cmd.op = DP_LATB; state_in = S_R1; end
         S_R1: begin
            cmd.op = DP_RDLOC;
            cmd.sel = (op == OP_AT) ? SEL_A : SEL_B;
            state_in = S_X;
         end
         S_X: begin
            cmd.op = DP_LATX;
            cmd.sel = (op == OP_AT) ? SEL_A : SEL_B;
            state_in = S_R2;
         end
         S_R2: begin
            cmd.op = DP_RDLOC;
            cmd.sel = (op == OP_AT) ? SEL_X : SEL_A;
            state_in = S_Y;
         end
         S_Y: begin
            cmd.op = DP_LATY;
            cmd.sel = (op == OP_AT) ? SEL_X : SEL_A;
            state_in = S_R3;
         end
         S_R3: state_in = S_EXEC;
         S_EXEC: begin cmd.op = DP_EXEC; state_in = S_RSP; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire
